// File: rtl/ttm_pkg.sv
// Shared constants and controller/datapath interface types for the task time monitor.
package ttm_pkg;

   localparam int TS_W       = 32;
   localparam int TIME_W     = 16;
   localparam int GROUP_W    = 3;
   localparam int WARM_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = 16'hffff;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STOP  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_UNIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALL_OVERHEAD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_GROUP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_GROUP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_PERIODS = 3'd4;

   localparam logic [TIME_W-1:0]  RST_TICKS_PER_UNIT = 16'd1;
   localparam logic [TIME_W-1:0]  RST_CALL_OVERHEAD  = 16'd0;
   localparam logic [GROUP_W-1:0] RST_PERIODIC_GROUP = 3'd0;
   localparam logic [GROUP_W-1:0] RST_IDLE_GROUP     = 3'd7;
   localparam logic [WARM_W-1:0]  RST_WARMUP_PERIODS = 4'd9;

   typedef struct packed {
      logic capture;
      logic launch;
      logic post;
      logic finish;
   } ttm_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } ttm_sts_type;

endpackage

// File: rtl/task_time_monitor.sv
// Top level of the task time monitor: controller and datapath.
//
// A start or stop transaction passes through acceptance, where the store read happens,
// the divider load, the bit-serial divider, which produces one quotient bit per cycle,
// the divider's done flag, overhead removal with saturation, and retirement, which
// registers the result and waits while an earlier result has not been taken. The
// next transaction can be accepted in the cycle after retirement. req_ready is high
// while no transaction is in flight; a result waiting in the output register does not
// hold off acceptance. Configuration writes are taken in any cycle (csr_ready is tied
// high) and should be made while the block is idle.
module task_time_monitor
   import ttm_pkg::*;
#(
   parameter int GROUPS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [GROUP_W-1:0]    req_group,
   input  logic [TS_W-1:0]       req_timestamp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TIME_W-1:0]     rsp_period_time,
   output logic                  rsp_period_valid,
   output logic [TIME_W-1:0]     rsp_max_period,
   output logic [TIME_W-1:0]     rsp_exec_time,
   output logic [TIME_W-1:0]     rsp_max_exec,
   output logic [TIME_W-1:0]     rsp_idle_max,
   output logic [TIME_W-1:0]     rsp_idle_min,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ttm_cmd_type cmd;
   ttm_sts_type sts;

   assign csr_ready = 1'b1;

   ttm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ttm_datapath #(
      .GROUPS (GROUPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_group        (req_group),
      .req_timestamp    (req_timestamp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period_time  (rsp_period_time),
      .rsp_period_valid (rsp_period_valid),
      .rsp_max_period   (rsp_max_period),
      .rsp_exec_time    (rsp_exec_time),
      .rsp_max_exec     (rsp_max_exec),
      .rsp_idle_max     (rsp_idle_max),
      .rsp_idle_min     (rsp_idle_min),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

// File: rtl/ttm_div.sv
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
module ttm_div
   import ttm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TS_W-1:0]   dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [TS_W-1:0]   quotient
);

   localparam int STEPS = TS_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [TIME_W-1:0] dvs_ff;
   logic [TS_W-1:0]   quo_ff;

   logic [TIME_W:0] shifted;
   logic [TIME_W:0] diff;
   logic            ge;

   assign shifted = {rem_ff, quo_ff[TS_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quo_ff <= {quo_ff[TS_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/ttm_ctrl.sv
// Sequencing state machine: capture, divide, post-process and retire one transaction.
module ttm_ctrl
   import ttm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output ttm_cmd_type cmd,
   input  ttm_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_POST,
      ST_FINISH
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (sts.div_done) state_ff <= ST_POST;
            end
            ST_POST: state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (sts.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.launch  = (state_ff == ST_LAUNCH);
   assign cmd.post    = (state_ff == ST_POST);
   assign cmd.finish  = (state_ff == ST_FINISH) && sts.out_free;

endmodule

// File: rtl/ttm_datapath.sv
// Datapath: registers, per-group stores, divider, saturation, maxima and idle accounting.
module ttm_datapath
   import ttm_pkg::*;
#(
   parameter int GROUPS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ttm_cmd_type           cmd,
   output ttm_sts_type           sts,
   input  logic                  req_mode,
   input  logic [GROUP_W-1:0]    req_group,
   input  logic [TS_W-1:0]       req_timestamp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TIME_W-1:0]     rsp_period_time,
   output logic                  rsp_period_valid,
   output logic [TIME_W-1:0]     rsp_max_period,
   output logic [TIME_W-1:0]     rsp_exec_time,
   output logic [TIME_W-1:0]     rsp_max_exec,
   output logic [TIME_W-1:0]     rsp_idle_max,
   output logic [TIME_W-1:0]     rsp_idle_min,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int GW    = $clog2(GROUPS);
   localparam int GEXTW = 7;

   // configuration
   logic [TIME_W-1:0]  ticks_ff;
   logic [TIME_W-1:0]  ovh_ff;
   logic [GROUP_W-1:0] per_grp_ff;
   logic [GROUP_W-1:0] idle_grp_ff;
   logic [WARM_W-1:0]  warm_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff    <= RST_TICKS_PER_UNIT;
         ovh_ff      <= RST_CALL_OVERHEAD;
         per_grp_ff  <= RST_PERIODIC_GROUP;
         idle_grp_ff <= RST_IDLE_GROUP;
         warm_cfg_ff <= RST_WARMUP_PERIODS;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TICKS_PER_UNIT: ticks_ff    <= csr_wdata;
            CSR_CALL_OVERHEAD:  ovh_ff      <= csr_wdata;
            CSR_PERIODIC_GROUP: per_grp_ff  <= csr_wdata[GROUP_W-1:0];
            CSR_IDLE_GROUP:     idle_grp_ff <= csr_wdata[GROUP_W-1:0];
            CSR_WARMUP_PERIODS: warm_cfg_ff <= csr_wdata[WARM_W-1:0];
            default: ;
         endcase
      end
   end

   // per-group stores
   logic [TS_W-1:0]   stamp_mem_ff [GROUPS];
   logic [TIME_W-1:0] lexec_mem_ff [GROUPS];
   logic [TIME_W-1:0] lper_mem_ff  [GROUPS];
   logic [GROUPS-1:0] armed_ff;
   logic [GROUPS-1:0] lexec_vld_ff;
   logic [GROUPS-1:0] lper_vld_ff;

   // idle accounting
   logic [TIME_W-1:0] idle_total_ff;
   logic [TIME_W-1:0] idle_high_ff;
   logic [TIME_W-1:0] idle_low_ff;
   logic [WARM_W-1:0] warm_seen_ff;

   // captured transaction
   logic               mode_ff;
   logic [GROUP_W-1:0] group_ff;
   logic [GW-1:0]      idx_ff;
   logic               inrange_ff;
   logic [TS_W-1:0]    ts_ff;
   logic [TS_W-1:0]    stamp_rd_ff;
   logic [TIME_W-1:0]  lexec_rd_ff;
   logic [TIME_W-1:0]  lper_rd_ff;
   logic               lexec_vld_rd_ff;
   logic               lper_vld_rd_ff;
   logic               armed_rd_ff;
   logic [TIME_W-1:0]  t16_ff;

   logic [GEXTW-1:0] req_grp_ext;
   logic [GW-1:0]    req_idx;
   logic             req_inrange;

   assign req_grp_ext = GEXTW'(req_group);
   assign req_idx     = req_grp_ext[GW-1:0];
   assign req_inrange = req_grp_ext < GEXTW'(GROUPS);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff         <= req_mode;
         group_ff        <= req_group;
         idx_ff          <= req_idx;
         inrange_ff      <= req_inrange;
         ts_ff           <= req_timestamp;
         stamp_rd_ff     <= stamp_mem_ff[req_idx];
         lexec_rd_ff     <= lexec_mem_ff[req_idx];
         lper_rd_ff      <= lper_mem_ff[req_idx];
         lexec_vld_rd_ff <= req_inrange ? lexec_vld_ff[req_idx] : 1'b0;
         lper_vld_rd_ff  <= req_inrange ? lper_vld_ff[req_idx] : 1'b0;
         armed_rd_ff     <= req_inrange ? armed_ff[req_idx] : 1'b0;
      end
   end

   // divide
   logic [TS_W-1:0]   div_dividend;
   logic [TIME_W-1:0] div_divisor;
   logic [TS_W-1:0]   quotient;
   logic              div_done;

   assign div_dividend = ts_ff - stamp_rd_ff;
   assign div_divisor  = (ticks_ff == '0) ? TIME_W'(1) : ticks_ff;

   ttm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.launch),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // overhead removal and saturation
   logic [TS_W-1:0]   ovh_ext;
   logic [TS_W-1:0]   q_adj;
   logic [TIME_W-1:0] t16_in;

   assign ovh_ext = TS_W'(ovh_ff);
   always_comb begin
      if (mode_ff == MODE_STOP) begin
         q_adj = (quotient > ovh_ext) ? (quotient - ovh_ext) : '0;
      end else begin
         q_adj = quotient;
      end
      t16_in = (q_adj > TS_W'(TIME_MAX)) ? TIME_MAX : q_adj[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.post) t16_ff <= t16_in;
   end

   // retire
   logic              is_start;
   logic              is_stop;
   logic [TIME_W-1:0] lper_cur;
   logic [TIME_W-1:0] lexec_cur;
   logic [TIME_W-1:0] per_out;
   logic              pvalid_out;
   logic [TIME_W-1:0] exec_out;
   logic [TIME_W-1:0] lper_in;
   logic [TIME_W-1:0] lexec_in;
   logic [TIME_W:0]   idle_sum;
   logic [TIME_W-1:0] idle_sat;
   logic              warm_done;

   assign is_start   = inrange_ff && (mode_ff == MODE_START);
   assign is_stop    = inrange_ff && (mode_ff == MODE_STOP);
   assign lper_cur   = lper_vld_rd_ff ? lper_rd_ff : '0;
   assign lexec_cur  = lexec_vld_rd_ff ? lexec_rd_ff : '0;
   assign pvalid_out = is_start && armed_rd_ff;
   assign per_out    = pvalid_out ? t16_ff : '0;
   assign exec_out   = is_stop ? t16_ff : '0;
   assign lper_in    = (per_out > lper_cur) ? per_out : lper_cur;
   assign lexec_in   = (exec_out > lexec_cur) ? exec_out : lexec_cur;
   assign idle_sum   = {1'b0, idle_total_ff} + {1'b0, t16_ff};
   assign idle_sat   = idle_sum[TIME_W] ? TIME_MAX : idle_sum[TIME_W-1:0];
   assign warm_done  = warm_seen_ff >= warm_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= '0;
         lexec_vld_ff  <= '0;
         lper_vld_ff   <= '0;
         idle_total_ff <= '0;
         idle_high_ff  <= '0;
         idle_low_ff   <= TIME_MAX;
         warm_seen_ff  <= '0;
      end else if (cmd.finish) begin
         if (is_start) begin
            armed_ff[idx_ff]    <= 1'b1;
            lper_vld_ff[idx_ff] <= 1'b1;
            if (group_ff == per_grp_ff) begin
               if (warm_done) begin
                  if (idle_total_ff > idle_high_ff) idle_high_ff <= idle_total_ff;
                  if (idle_total_ff < idle_low_ff) idle_low_ff <= idle_total_ff;
               end else begin
                  warm_seen_ff <= warm_seen_ff + 1'b1;
               end
               idle_total_ff <= '0;
            end
         end
         if (is_stop) begin
            lexec_vld_ff[idx_ff] <= 1'b1;
            if (group_ff == idle_grp_ff) idle_total_ff <= idle_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && is_start) begin
         stamp_mem_ff[idx_ff] <= ts_ff;
         lper_mem_ff[idx_ff]  <= lper_in;
      end
      if (cmd.finish && is_stop) begin
         lexec_mem_ff[idx_ff] <= lexec_in;
      end
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_period_time  <= per_out;
         rsp_period_valid <= pvalid_out;
         rsp_max_period   <= inrange_ff ? lper_in : '0;
         rsp_exec_time    <= exec_out;
         rsp_max_exec     <= inrange_ff ? lexec_in : '0;
         rsp_idle_max     <= (is_start && group_ff == per_grp_ff && warm_done &&
                              idle_total_ff > idle_high_ff) ? idle_total_ff : idle_high_ff;
         rsp_idle_min     <= (is_start && group_ff == per_grp_ff && warm_done &&
                              idle_total_ff < idle_low_ff) ? idle_total_ff : idle_low_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/ttm_checker.sv
// Port-level checks for the task time monitor, bound to the top level.
module ttm_checker
   import ttm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [TIME_W-1:0]     rsp_period_time,
   input logic                  rsp_period_valid,
   input logic [TIME_W-1:0]     rsp_max_period,
   input logic [TIME_W-1:0]     rsp_exec_time,
   input logic [TIME_W-1:0]     rsp_max_exec
);

   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while one is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   a_period_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_period_valid) |-> (rsp_period_time == '0))
      else $error("period reported without a valid period");

   a_period_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_max_period >= rsp_period_time))
      else $error("period exceeds its group maximum");

   a_exec_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_max_exec >= rsp_exec_time))
      else $error("execution time exceeds its group maximum");

endmodule

bind task_time_monitor ttm_checker u_ttm_checker (.*);

// File: tb/tb_task_time_monitor.sv
// Self-checking testbench for the task time monitor: directed and random start/stop traffic.
module tb_task_time_monitor;
   import ttm_pkg::*;

   localparam int GROUP_COUNT   = 8;
   localparam int PHASES        = 8;
   localparam int PHASE_EVENTS  = 62;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 80;
   localparam int QUIET_LIMIT   = 4000;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_WARMUP_PERIODS + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNUSED  = '1;

   typedef struct packed {
      logic                 mode;
      logic [GROUP_W-1:0]   grp;
      logic [TS_W-1:0]      stamp;
   } task_event_type;

   typedef struct packed {
      logic [TIME_W-1:0] period_time;
      logic              period_valid;
      logic [TIME_W-1:0] max_period;
      logic [TIME_W-1:0] exec_time;
      logic [TIME_W-1:0] max_exec;
      logic [TIME_W-1:0] idle_max;
      logic [TIME_W-1:0] idle_min;
   } timing_report_type;

   typedef enum logic [1:0] {STEP_EVENT, STEP_WRITE, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type         kind;
      task_event_type        ev;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } step_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_mode      = MODE_START;
   logic [GROUP_W-1:0]    req_group     = '0;
   logic [TS_W-1:0]       req_timestamp = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [TIME_W-1:0]     rsp_period_time;
   logic                  rsp_period_valid;
   logic [TIME_W-1:0]     rsp_max_period;
   logic [TIME_W-1:0]     rsp_exec_time;
   logic [TIME_W-1:0]     rsp_max_exec;
   logic [TIME_W-1:0]     rsp_idle_max;
   logic [TIME_W-1:0]     rsp_idle_min;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   task_time_monitor #(.GROUPS(GROUP_COUNT)) dut (.*);

   always #2 clock = ~clock;

   // predicted configuration and state
   logic [TIME_W-1:0]  cfg_ticks    = RST_TICKS_PER_UNIT;
   logic [TIME_W-1:0]  cfg_overhead = RST_CALL_OVERHEAD;
   logic [GROUP_W-1:0] cfg_periodic = RST_PERIODIC_GROUP;
   logic [GROUP_W-1:0] cfg_idle     = RST_IDLE_GROUP;
   logic [WARM_W-1:0]  cfg_warmup   = RST_WARMUP_PERIODS;

   logic [TS_W-1:0]    start_stamp    [GROUP_COUNT];
   logic               armed          [GROUP_COUNT] = '{default: 1'b0};
   logic [TIME_W-1:0]  longest_exec   [GROUP_COUNT] = '{default: '0};
   logic [TIME_W-1:0]  longest_period [GROUP_COUNT] = '{default: '0};
   logic [TIME_W-1:0]  idle_sum   = '0;
   logic [TIME_W-1:0]  idle_high  = '0;
   logic [TIME_W-1:0]  idle_low   = TIME_MAX;
   logic [WARM_W-1:0]  warm_count = '0;

   timing_report_type expected_reports [$];
   step_type          pending_steps [$];
   int unsigned       fail_count    = 0;
   logic              stimulus_done = 1'b0;

   // stimulus generator state
   logic [TIME_W-1:0]  gen_ticks    = RST_TICKS_PER_UNIT;
   logic [TIME_W-1:0]  gen_overhead = RST_CALL_OVERHEAD;
   logic [GROUP_W-1:0] gen_periodic = RST_PERIODIC_GROUP;
   logic [GROUP_W-1:0] gen_idle     = RST_IDLE_GROUP;
   logic [TS_W-1:0]    stamp_now;
   logic               started [GROUP_COUNT] = '{default: 1'b0};
   int unsigned        events_queued = 0;

   function automatic logic [TIME_W-1:0] scaled_time(input logic [TS_W-1:0] ticks,
                                                     input logic [TIME_W-1:0] less);
      logic [TS_W-1:0] q;
      q = ticks / ((cfg_ticks == '0) ? TS_W'(1) : TS_W'(cfg_ticks));
      q = (q > TS_W'(less)) ? q - TS_W'(less) : '0;
      return (q > TS_W'(TIME_MAX)) ? TIME_MAX : q[TIME_W-1:0];
   endfunction

   function automatic timing_report_type predict_report(input task_event_type ev);
      timing_report_type r;
      logic [TIME_W:0] sum;
      r = '0;
      if (ev.mode == MODE_START) begin
         if (ev.grp == cfg_periodic) begin
            if (warm_count >= cfg_warmup) begin
               if (idle_sum > idle_high) idle_high = idle_sum;
               if (idle_sum < idle_low) idle_low = idle_sum;
            end else begin
               warm_count = warm_count + 1'b1;
            end
            idle_sum = '0;
         end
         if (armed[ev.grp]) begin
            r.period_time  = scaled_time(ev.stamp - start_stamp[ev.grp], '0);
            r.period_valid = 1'b1;
            if (r.period_time > longest_period[ev.grp]) longest_period[ev.grp] = r.period_time;
         end else begin
            armed[ev.grp] = 1'b1;
         end
         start_stamp[ev.grp] = ev.stamp;
      end else begin
         r.exec_time = scaled_time(ev.stamp - start_stamp[ev.grp], cfg_overhead);
         if (r.exec_time > longest_exec[ev.grp]) longest_exec[ev.grp] = r.exec_time;
         if (ev.grp == cfg_idle) begin
            sum      = {1'b0, idle_sum} + {1'b0, r.exec_time};
            idle_sum = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
         end
      end
      r.max_period = longest_period[ev.grp];
      r.max_exec   = longest_exec[ev.grp];
      r.idle_max   = idle_high;
      r.idle_min   = idle_low;
      return r;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_TICKS_PER_UNIT: cfg_ticks    = d;
         CSR_CALL_OVERHEAD:  cfg_overhead = d;
         CSR_PERIODIC_GROUP: cfg_periodic = d[GROUP_W-1:0];
         CSR_IDLE_GROUP:     cfg_idle     = d[GROUP_W-1:0];
         CSR_WARMUP_PERIODS: cfg_warmup   = d[WARM_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [TS_W-1:0] next_stamp();
      logic [TS_W-1:0] unit;
      int unsigned     pick;
      unit = (gen_ticks == '0) ? TS_W'(1) : TS_W'(gen_ticks);
      pick = $urandom_range(0, 99);
      if (pick < 35)
         stamp_now += unit * $urandom_range(0, 40) + $urandom_range(0, unit - 1);
      else if (pick < 60)
         stamp_now += unit * $urandom_range(0, 70000);
      else if (pick < 78)
         stamp_now += unit * (TS_W'(gen_overhead) + $urandom_range(65530, 65540));
      else if (pick < 92)
         stamp_now += $urandom_range(0, 1 << 24);
      else
         stamp_now += $urandom;
      return stamp_now;
   endfunction

   task automatic add_event_at(input logic m, input logic [GROUP_W-1:0] g,
                               input logic [TS_W-1:0] ts);
      step_type s;
      s.kind = STEP_EVENT;
      s.ev   = {m, g, ts};
      s.idx  = '0;
      s.data = '0;
      pending_steps.push_back(s);
      if (m == MODE_START) started[g] = 1'b1;
      events_queued++;
   endtask

   task automatic add_event(input logic m, input logic [GROUP_W-1:0] g);
      add_event_at(m, g, next_stamp());
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      step_type s;
      s.kind = STEP_WRITE;
      s.ev   = '0;
      s.idx  = idx;
      s.data = d;
      pending_steps.push_back(s);
   endtask

   task automatic add_drain();
      step_type s;
      s.kind = STEP_DRAIN;
      s.ev   = '0;
      s.idx  = '0;
      s.data = '0;
      pending_steps.push_back(s);
   endtask

   // group and warm-up registers carry random upper bits, which must be ignored
   task automatic configure(input logic [TIME_W-1:0] ticks, input logic [TIME_W-1:0] ovh,
                            input logic [GROUP_W-1:0] per, input logic [GROUP_W-1:0] idl,
                            input logic [WARM_W-1:0] warm);
      logic [CSR_DATA_W-1:0] d;
      add_write(CSR_TICKS_PER_UNIT, ticks);
      add_write(CSR_CALL_OVERHEAD, ovh);
      d = CSR_DATA_W'($urandom);
      d[GROUP_W-1:0] = per;
      add_write(CSR_PERIODIC_GROUP, d);
      d = CSR_DATA_W'($urandom);
      d[GROUP_W-1:0] = idl;
      add_write(CSR_IDLE_GROUP, d);
      d = CSR_DATA_W'($urandom);
      d[WARM_W-1:0] = warm;
      add_write(CSR_WARMUP_PERIODS, d);
      gen_ticks    = ticks;
      gen_overhead = ovh;
      gen_periodic = per;
      gen_idle     = idl;
   endtask

   // driver
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned quiet_run  = 0;

   always @(posedge clock) begin
      logic     next_req;
      logic     next_csr;
      step_type head;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_req = req_valid;
         next_csr = csr_valid;
         if (req_valid && req_ready) begin
            expected_reports.push_back(predict_report({req_mode, req_group, req_timestamp}));
            next_req = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_wdata);
            next_csr = 1'b0;
         end
         if (expected_reports.size() == 0 && !next_req) quiet_run++;
         else quiet_run = 0;
         if (!next_req && !next_csr && pending_steps.size() != 0) begin
            head = pending_steps[0];
            case (head.kind)
               STEP_EVENT: begin
                  if (gap_left != 0) begin
                     gap_left--;
                  end else begin
                     void'(pending_steps.pop_front());
                     req_mode      <= head.ev.mode;
                     req_group     <= head.ev.grp;
                     req_timestamp <= head.ev.stamp;
                     next_req = 1'b1;
                     if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 45);
                     end else begin
                        burst_left--;
                     end
                  end
               end
               STEP_WRITE: begin
                  if (quiet_run >= SETTLE_CYCLES) begin
                     void'(pending_steps.pop_front());
                     csr_index <= head.idx;
                     csr_wdata <= head.data;
                     next_csr = 1'b1;
                  end
               end
               default: begin
                  if (expected_reports.size() == 0) void'(pending_steps.pop_front());
               end
            endcase
         end
         req_valid     <= next_req;
         csr_valid     <= next_csr;
         stimulus_done <= (pending_steps.size() == 0) && !next_req && !next_csr;
      end
   end

   // receiver stalls, with stall-free windows
   int unsigned sink_hold   = 0;
   logic [11:0] sink_cycles = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (sink_hold == 0) begin
            rsp_ready <= (sink_cycles[11:10] == 2'b00) || ($urandom_range(0, 2) != 0);
            sink_hold <= $urandom_range(0, 24);
         end else begin
            sink_hold <= sink_hold - 1;
         end
         sink_cycles <= sink_cycles + 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      timing_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("result transaction with no expectation outstanding");
            fail_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("period_time", want.period_time, rsp_period_time);
            check_field("period_valid", TIME_W'(want.period_valid), TIME_W'(rsp_period_valid));
            check_field("max_period", want.max_period, rsp_max_period);
            check_field("exec_time", want.exec_time, rsp_exec_time);
            check_field("max_exec", want.max_exec, rsp_max_exec);
            check_field("idle_max", want.idle_max, rsp_idle_max);
            check_field("idle_min", want.idle_min, rsp_idle_min);
         end
      end
   end

   // watchdog
   int unsigned stalled_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      int unsigned        pick;
      int unsigned        mark;
      logic               m;
      logic [GROUP_W-1:0] g;
      logic [TIME_W-1:0]  ticks_sel;
      logic [TIME_W-1:0]  ovh_sel;
      logic [WARM_W-1:0]  warm_sel;

      stamp_now = $urandom;

      // reset configuration: arming, saturation, exact limit, wrap, zero execution time
      add_event_at(MODE_START, 3'd0, 32'h0000_0000);
      add_event_at(MODE_START, 3'd7, 32'h0000_0010);
      add_event_at(MODE_STOP,  3'd7, 32'h0000_0030);
      add_event_at(MODE_START, 3'd0, 32'h0001_0000);
      add_event_at(MODE_START, 3'd0, 32'h0001_ffff);
      add_event_at(MODE_START, 3'd5, 32'hffff_fff0);
      add_event_at(MODE_STOP,  3'd5, 32'h0000_0010);
      add_event_at(MODE_START, 3'd5, 32'h0000_0005);
      add_event_at(MODE_STOP,  3'd5, 32'hffff_ffff);
      add_event_at(MODE_START, 3'd3, 32'haaaa_aaaa);
      add_event_at(MODE_STOP,  3'd3, 32'haaaa_aaaa);
      add_event_at(MODE_START, 3'd6, 32'h5555_5555);
      add_event_at(MODE_STOP,  3'd6, 32'hd555_5555);
      add_drain();

      // zero divisor, full overhead, no warm-up, unknown register index
      configure('0, TIME_MAX, 3'd3, 3'd6, '0);
      add_write(CSR_FIRST_UNUSED, '1);
      add_write(CSR_LAST_UNUSED, '1);
      add_event_at(MODE_START, 3'd6, 32'h0000_1000);
      add_event_at(MODE_STOP,  3'd6, 32'h0002_0000);
      add_event_at(MODE_STOP,  3'd6, 32'h0000_1001);
      add_event_at(MODE_START, 3'd3, 32'h1234_5678);

      // largest divisor
      configure(TIME_MAX, 16'd5, 3'd3, 3'd6, '0);
      add_event_at(MODE_START, 3'd6, 32'h0000_0000);
      add_event_at(MODE_STOP,  3'd6, 32'hffff_ffff);
      add_event_at(MODE_START, 3'd3, 32'h8000_0000);
      add_event_at(MODE_START, 3'd3, 32'h8000_0001);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            ticks_sel = 16'd1;
            ovh_sel   = '0;
            warm_sel  = '0;
         end else if (p == 1) begin
            ticks_sel = TIME_MAX;
            ovh_sel   = TIME_MAX;
            warm_sel  = '1;
         end else begin
            ticks_sel = (p == 2) ? '0 :
                        TIME_W'($urandom_range(0, 1) ? $urandom_range(1, 16) :
                                                       $urandom_range(1, 65535));
            pick      = $urandom_range(0, 2);
            ovh_sel   = (pick == 0) ? '0 :
                        TIME_W'((pick == 1) ? $urandom_range(0, 40) :
                                              $urandom_range(0, 65535));
            warm_sel  = WARM_W'($urandom_range(0, 15));
         end
         configure(ticks_sel, ovh_sel, GROUP_W'($urandom_range(0, GROUP_COUNT - 1)),
                   GROUP_W'($urandom_range(0, GROUP_COUNT - 1)), warm_sel);
         if ($urandom_range(0, 1))
            add_write(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                      CSR_DATA_W'($urandom));

         mark = events_queued;
         while (events_queued - mark < PHASE_EVENTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               add_event(MODE_START, gen_periodic);
               repeat ($urandom_range(1, 4)) begin
                  g = $urandom_range(0, 1) ? gen_idle :
                      GROUP_W'($urandom_range(0, GROUP_COUNT - 1));
                  add_event(MODE_START, g);
                  add_event(MODE_STOP, g);
                  if ($urandom_range(0, 4) == 0) add_event(MODE_STOP, g);
               end
            end else if (pick < 96) begin
               m = 1'($urandom_range(0, 1));
               g = GROUP_W'($urandom_range(0, GROUP_COUNT - 1));
               if (m == MODE_STOP && !started[g]) m = MODE_START;
               add_event_at(m, g, $urandom_range(0, 1) ? TS_W'($urandom) : next_stamp());
            end else begin
               add_drain();
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (!stimulus_done) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
